@@ src/gnd_pkg.sv @@
// Shared types and constants for the gradient noise core.
// Used by gradient_noise_2d_3d_core; depends on nothing.
package gnd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LAT_BITS  = 8;
  localparam int LAT_SIZE  = 1 << LAT_BITS;
  localparam int COORD_W   = 24;
  localparam int OUT_W     = 20;
  localparam int FX_W      = 24;
  localparam int PROD_W    = 2 * FX_W;
  localparam int NUM_GRAD_3D = 8;
  localparam int NUM_GRAD_2D = 4;

  typedef logic signed [FX_W-1:0]     fx_t;
  typedef logic [LAT_BITS-1:0]        idx_t;
  typedef logic [FRAC_BITS-1:0]       frac_t;
  typedef logic signed [OUT_W-1:0]    out_t;

  localparam fx_t ONE_FX     = fx_t'(1 << FRAC_BITS);
  localparam fx_t FIFTEEN_FX = fx_t'(15 << FRAC_BITS);
  localparam fx_t TEN_FX     = fx_t'(10 << FRAC_BITS);
  localparam fx_t OUT_MAX_FX = fx_t'(524287);
  localparam fx_t OUT_MIN_FX = -fx_t'(524288);

  typedef enum logic [1:0] {
    MODE_2D   = 2'd0,
    MODE_3D   = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FADE,
    ST_HASH,
    ST_GRAD,
    ST_LERP_D,
    ST_LERP_M
  } state_e;

  // Fixed-point product, truncated toward zero.
  function automatic fx_t fxmul(input fx_t a, input fx_t b);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] adj;
    begin
      p   = PROD_W'(a) * PROD_W'(b);
      adj = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
      fxmul = adj[FRAC_BITS +: FX_W];
    end
  endfunction

endpackage

@@ src/gnd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module gnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/gradient_noise_2d_3d_core.sv @@
// Gradient noise core: 2D and 3D lattice gradient noise over a loadable
// permutation table. Depends on gnd_pkg and gnd_ram.
//
// Usage:
//   Raise start_i with the item fields; a transaction is taken at a rising
//   edge where start_i is high and busy_o is low. mode_i picks the work:
//   2D noise, 3D noise, a permutation table load, or the unused code which
//   only returns zero. Each transaction gives exactly one result, shown on
//   noise_value_o for one cycle with done_o high; the receiver cannot stall.
// Throughput:
//   A load (or unused code) shows its result the cycle after acceptance and
//   never raises busy_o, so loads may be issued every cycle.
//   A noise sample raises busy_o and holds it until done_o. Its work
//   goes through one shared multiplier (four products per quintic fade,
//   one per lerp) and the single read port of the table, which serves
//   the dependent hash lookups one per cycle. busy_o drops in the
//   cycle done_o rises, so the next transaction can be taken right then.
// Reset:
//   Reset clears the sequencer and the result strobe. The table is not
//   cleared; load every entry before the first noise query.
module gradient_noise_2d_3d_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   mode_i,
  input  logic [gnd_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [gnd_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [gnd_pkg::COORD_W-1:0]  coord_z_i,
  input  logic [gnd_pkg::LAT_BITS-1:0] table_index_i,
  input  logic [gnd_pkg::LAT_BITS-1:0] table_value_i,
  output logic                         done_o,
  output logic signed [gnd_pkg::OUT_W-1:0] noise_value_o
);

  import gnd_pkg::*;

  // Sequencer state and counters
  state_e     state_q, state_d;
  logic       is3d_q;
  logic [1:0] ax_q;      // axis whose fade is being built
  logic [1:0] fstep_q;   // step within one fade
  logic [2:0] step_q;    // hash lookup step
  logic [3:0] gk_q;      // gradient read counter
  logic [3:0] cnt_q;     // entries in the blend queue
  logic [2:0] lc_q;      // lerps done

  // Latched operands
  frac_t frac_q [3];
  idx_t  cell_q [3];
  fx_t   inner_q, sq_q, cube_q, diff_q;
  fx_t   fade_q [3];
  idx_t  tmp0_q, tmp1_q;
  idx_t  h_q [4];
  fx_t   gq_q [NUM_GRAD_3D];

  logic  done_q;
  out_t  noise_q;

  // Table
  logic accept;
  logic ram_we;
  idx_t ram_raddr, ram_rdata;

  assign accept = start_i && !busy_o;
  assign ram_we = accept && (mode_i == MODE_LOAD);

  gnd_ram #(
    .WIDTH(LAT_BITS),
    .DEPTH(LAT_SIZE)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(table_index_i),
    .wdata_i(table_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Shared multiplier: operand selection by step
  fx_t t_fx, mul_a, mul_b, mul_res, lerp_t, lerp_res;
  logic [1:0] fsel;
  logic last_ax, last_hash;
  logic [3:0] num_grad;
  logic [2:0] app_idx;   // queue slot that takes the new lerp

  assign t_fx = fx_t'(frac_q[ax_q]);

  always_comb begin
    if (is3d_q) begin
      fsel = (lc_q < 3'd4) ? 2'd0 : ((lc_q < 3'd6) ? 2'd1 : 2'd2);
    end else begin
      fsel = (lc_q < 3'd2) ? 2'd0 : 2'd1;
    end
  end

  assign lerp_t = fade_q[fsel];

  always_comb begin
    mul_a = t_fx;
    mul_b = t_fx;
    if (state_q == ST_LERP_M) begin
      mul_a = lerp_t;
      mul_b = diff_q;
    end else begin
      case (fstep_q)
        2'd0: begin
          mul_b = (t_fx <<< 2) + (t_fx <<< 1) - FIFTEEN_FX;
        end
        2'd1: begin
          mul_b = t_fx;
        end
        2'd2: begin
          mul_a = sq_q;
        end
        default: begin
          mul_a = cube_q;
          mul_b = inner_q;
        end
      endcase
    end
  end

  assign mul_res  = fxmul(mul_a, mul_b);
  assign lerp_res = gq_q[0] + mul_res;
  assign app_idx  = 3'(cnt_q - 4'd2);

  assign last_ax   = is3d_q ? (ax_q == 2'd2) : (ax_q == 2'd1);
  assign last_hash = is3d_q ? (step_q == 3'd6) : (step_q == 3'd2);
  assign num_grad  = is3d_q ? 4'(NUM_GRAD_3D) : 4'(NUM_GRAD_2D);

  // Table read address
  always_comb begin
    ram_raddr = '0;
    case (state_q)
      ST_HASH: begin
        if (is3d_q) begin
          case (step_q)
            3'd0: ram_raddr = cell_q[0];
            3'd1: ram_raddr = idx_t'(cell_q[0] + 1'b1);
            3'd2: ram_raddr = idx_t'(tmp0_q + cell_q[1]);
            3'd3: ram_raddr = idx_t'(tmp0_q + cell_q[1] + 1'b1);
            3'd4: ram_raddr = idx_t'(tmp1_q + cell_q[1]);
            3'd5: ram_raddr = idx_t'(tmp1_q + cell_q[1] + 1'b1);
            default: ram_raddr = '0;
          endcase
        end else begin
          case (step_q)
            3'd0: ram_raddr = cell_q[1];
            3'd1: ram_raddr = idx_t'(cell_q[1] + 1'b1);
            default: ram_raddr = '0;
          endcase
        end
      end
      ST_GRAD: begin
        ram_raddr = idx_t'(h_q[gk_q[1:0]] + gk_q[2]);
      end
      default: ram_raddr = '0;
    endcase
  end

  // Gradient of the entry that arrives this cycle
  logic [2:0] gkm1;
  fx_t xo, yo, zo, gu, gv, grad;
  logic [3:0] hh;

  assign gkm1 = 3'(gk_q - 4'd1);
  assign xo   = gkm1[0] ? fx_t'(frac_q[0]) - ONE_FX : fx_t'(frac_q[0]);
  assign yo   = gkm1[1] ? fx_t'(frac_q[1]) - ONE_FX : fx_t'(frac_q[1]);
  assign zo   = gkm1[2] ? fx_t'(frac_q[2]) - ONE_FX : fx_t'(frac_q[2]);
  assign hh   = ram_rdata[3:0];

  always_comb begin
    if (is3d_q) begin
      gu = (hh < 4'd8) ? xo : yo;
      if (hh < 4'd4) begin
        gv = yo;
      end else if (hh == 4'd12 || hh == 4'd14) begin
        gv = xo;
      end else begin
        gv = zo;
      end
      grad = (hh[0] ? -gu : gu) + (hh[1] ? -gv : gv);
    end else begin
      gu   = (hh[2:0] < 3'd4) ? xo : yo;
      gv   = (hh[2:0] < 3'd4) ? yo : xo;
      grad = (hh[0] ? -gu : gu) + (hh[1] ? -(gv <<< 1) : (gv <<< 1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_2D || mode_i == MODE_3D)) begin
          state_d = ST_FADE;
        end
      end
      ST_FADE: begin
        if (fstep_q == 2'd3 && last_ax) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (last_hash) begin
          state_d = ST_GRAD;
        end
      end
      ST_GRAD: begin
        if (gk_q == num_grad) begin
          state_d = ST_LERP_D;
        end
      end
      ST_LERP_D: begin
        state_d = ST_LERP_M;
      end
      ST_LERP_M: begin
        state_d = (cnt_q == 4'd2) ? ST_IDLE : ST_LERP_D;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is3d_q  <= 1'b0;
      ax_q    <= '0;
      fstep_q <= '0;
      step_q  <= '0;
      gk_q    <= '0;
      cnt_q   <= '0;
      lc_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      // load and unused code answer at once; a sample after its last lerp
      done_q <= ((state_q == ST_IDLE) && accept &&
                 (mode_i == MODE_LOAD || mode_i == MODE_NONE)) ||
                ((state_q == ST_LERP_M) && (cnt_q == 4'd2));
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is3d_q  <= (mode_i == MODE_3D);
            ax_q    <= '0;
            fstep_q <= '0;
            step_q  <= '0;
            gk_q    <= '0;
            cnt_q   <= '0;
            lc_q    <= '0;
          end
        end
        ST_FADE: begin
          fstep_q <= fstep_q + 2'd1;
          if (fstep_q == 2'd3) begin
            ax_q <= ax_q + 2'd1;
          end
        end
        ST_HASH: begin
          step_q <= step_q + 3'd1;
        end
        ST_GRAD: begin
          gk_q <= gk_q + 4'd1;
          if (gk_q != 4'd0) begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_LERP_M: begin
          cnt_q <= cnt_q - 4'd1;
          lc_q  <= lc_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          frac_q[0] <= coord_x_i[FRAC_BITS-1:0];
          frac_q[1] <= coord_y_i[FRAC_BITS-1:0];
          frac_q[2] <= coord_z_i[FRAC_BITS-1:0];
          cell_q[0] <= coord_x_i[FRAC_BITS +: LAT_BITS];
          cell_q[1] <= coord_y_i[FRAC_BITS +: LAT_BITS];
          cell_q[2] <= coord_z_i[FRAC_BITS +: LAT_BITS];
          noise_q   <= '0;
        end
      end
      ST_FADE: begin
        case (fstep_q)
          2'd0: inner_q <= mul_res + TEN_FX;
          2'd1: sq_q    <= mul_res;
          2'd2: cube_q  <= mul_res;
          default: fade_q[ax_q] <= mul_res;
        endcase
      end
      ST_HASH: begin
        if (is3d_q) begin
          case (step_q)
            3'd1: tmp0_q <= ram_rdata;
            3'd2: tmp1_q <= ram_rdata;
            3'd3: h_q[0] <= idx_t'(ram_rdata + cell_q[2]);
            3'd4: h_q[2] <= idx_t'(ram_rdata + cell_q[2]);
            3'd5: h_q[1] <= idx_t'(ram_rdata + cell_q[2]);
            3'd6: h_q[3] <= idx_t'(ram_rdata + cell_q[2]);
            default: begin
            end
          endcase
        end else begin
          case (step_q)
            3'd1: begin
              h_q[0] <= idx_t'(cell_q[0] + ram_rdata);
              h_q[1] <= idx_t'(cell_q[0] + ram_rdata + 1'b1);
            end
            3'd2: begin
              h_q[2] <= idx_t'(cell_q[0] + ram_rdata);
              h_q[3] <= idx_t'(cell_q[0] + ram_rdata + 1'b1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_GRAD: begin
        if (gk_q != 4'd0) begin
          gq_q[gkm1] <= grad;
        end
      end
      ST_LERP_D: begin
        diff_q <= gq_q[1] - gq_q[0];
      end
      ST_LERP_M: begin
        // drop the two blended entries, append the lerp at the tail
        for (int i = 0; i < NUM_GRAD_3D - 2; i++) begin
          if (app_idx == 3'(i)) begin
            gq_q[i] <= lerp_res;
          end else begin
            gq_q[i] <= gq_q[i+2];
          end
        end
        if (app_idx == 3'(NUM_GRAD_3D - 2)) begin
          gq_q[NUM_GRAD_3D-2] <= lerp_res;
        end
        if (cnt_q == 4'd2) begin
          if (lerp_res > OUT_MAX_FX) begin
            noise_q <= OUT_MAX_FX[OUT_W-1:0];
          end else if (lerp_res < OUT_MIN_FX) begin
            noise_q <= OUT_MIN_FX[OUT_W-1:0];
          end else begin
            noise_q <= lerp_res[OUT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign noise_value_o = noise_q;

  // A load answers zero in the next cycle
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_LOAD) |=> (done_o && noise_value_o == '0))
    else $error("load did not return zero result");

  // Blending always has two queue entries to combine
  a_lerp_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LERP_D) |-> (cnt_q >= 4'd2))
    else $error("blend queue underflow");

  // The final lerp delivers the result and frees the core
  a_final_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LERP_M && cnt_q == 4'd2) |=> (done_o && !busy_o))
    else $error("final blend did not deliver a result");

endmodule
